// ----- hdl/sstx_pkg.sv -----
package sstx_pkg;

  localparam int unsigned NumDigits  = 3;
  localparam int unsigned TextBytes  = 7;
  localparam int unsigned TextW      = 8 * TextBytes;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = TextW;

  localparam logic [7:0] DpBit        = 8'b1000_0000;
  localparam logic [7:0] PatSpace     = 8'h00;
  localparam logic [7:0] PatDegree    = 8'b1100_0011;
  localparam logic [7:0] PatDash      = 8'b0100_0000;
  localparam logic [7:0] ChrDot       = 8'h2E;
  localparam logic [7:0] ChrSpace     = 8'h20;
  localparam logic [7:0] ChrCaret     = 8'h5E;
  localparam logic [7:0] ChrDash      = 8'h2D;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrNine      = 8'h39;
  localparam logic [7:0] ChrLowA      = 8'h61;
  localparam logic [7:0] ChrLowZ      = 8'h7A;
  localparam logic [7:0] ChrUpA       = 8'h41;
  localparam logic [7:0] ChrUpZ       = 8'h5A;
  localparam logic [PeriodW-1:0] PeriodReset = 8'd5;
  localparam logic [PeriodW-1:0] PeriodMax   = 8'hFF;

  localparam logic [7:0] NUM_PAT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  localparam logic [7:0] ALPHA_PAT [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h04, 8'h1E,
    8'h7A, 8'h38, 8'h55, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h7E, 8'h6A, 8'h36, 8'h6E, 8'h49
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEXT   = 2'd0,
    REG_PERIOD = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic       fire;
    logic [7:0] segments_n;
    logic [2:0] select_n;
  } scan_res_t;

endpackage

// ----- hdl/sstx_if.sv -----
interface sstx_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface sstx_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments_n;
  logic [2:0] select_n;

  modport source (output valid, output segments_n, output select_n, input ready);
  modport sink   (input valid, input segments_n, input select_n, output ready);
endinterface

// ----- hdl/sstx_decode.sv -----
module sstx_decode (
  input  logic [7:0] char_i,
  input  logic       dp_i,
  output logic [7:0] segments_n_o
);
  import sstx_pkg::*;

  logic [7:0] pat;
  logic [7:0] ofs;

  always_comb begin
    ofs = 8'h00;
    pat = char_i;
    if (char_i inside {[ChrZero:ChrNine]}) begin
      ofs = char_i - ChrZero;
      pat = NUM_PAT[ofs[3:0]];
    end else if (char_i inside {[ChrLowA:ChrLowZ]}) begin
      ofs = char_i - ChrLowA;
      pat = ALPHA_PAT[ofs[4:0]];
    end else if (char_i inside {[ChrUpA:ChrUpZ]}) begin
      ofs = char_i - ChrUpA;
      pat = ALPHA_PAT[ofs[4:0]];
    end else if (char_i == ChrSpace) begin
      pat = PatSpace;
    end else if (char_i == ChrCaret) begin
      pat = PatDegree;
    end else if (char_i == ChrDash) begin
      pat = PatDash;
    end
    segments_n_o = ~(dp_i ? (pat | DpBit) : pat);
  end

endmodule

// ----- hdl/sstx_scan.sv -----
module sstx_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [sstx_pkg::TextW-1:0]   text_i,
  input  logic [sstx_pkg::PeriodW-1:0] period_i,
  output sstx_pkg::scan_res_t         res_o
);
  import sstx_pkg::*;

  logic [PeriodW-1:0] elapsed_q, elapsed_d;
  logic [1:0]         digit_q, digit_d;
  logic [2:0]         pos_q, pos_d;

  logic [PeriodW-1:0] inc;
  logic [PeriodW-1:0] period_eff;
  logic               fire;
  logic [1:0]         digit0;
  logic [2:0]         pos0, pos1;
  logic [7:0]         byte0, byte1;
  logic               dp;
  logic [2:0]         sel_hot;

  function automatic logic [7:0] text_byte(logic [TextW-1:0] text, logic [2:0] pos);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < TextBytes; i++) begin
      if (pos == 3'(i)) begin
        b = text[8*i +: 8];
      end
    end
    return b;
  endfunction

  always_comb begin
    inc        = (elapsed_q == PeriodMax) ? PeriodMax : elapsed_q + 1'b1;
    period_eff = (period_i == '0) ? PeriodW'(1) : period_i;
    fire       = (inc >= period_eff);

    if (digit_q >= 2'(NumDigits)) begin
      digit0 = 2'd0;
      pos0   = 3'd0;
    end else begin
      digit0 = digit_q;
      pos0   = pos_q;
    end

    byte0   = text_byte(text_i, pos0);
    pos1    = pos0 + 3'd1;
    byte1   = text_byte(text_i, pos1);
    dp      = (byte1 == ChrDot);
    sel_hot = 3'b001 << digit0;

    elapsed_d = elapsed_q;
    digit_d   = digit_q;
    pos_d     = pos_q;
    if (step_i) begin
      elapsed_d = fire ? '0 : inc;
      if (fire) begin
        digit_d = digit0 + 2'd1;
        pos_d   = dp ? (pos1 + 3'd1) : pos1;
      end
    end
  end

  sstx_decode u_decode (
    .char_i       (byte0),
    .dp_i         (dp),
    .segments_n_o (res_o.segments_n)
  );

  assign res_o.fire     = fire;
  assign res_o.select_n = ~sel_hot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      digit_q   <= '0;
      pos_q     <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      digit_q   <= digit_d;
      pos_q     <= pos_d;
    end
  end

endmodule

// ----- hdl/seven_segment_text_scanner_core.sv -----
// Channel   Dir  Word                         Role
// in_i      in   tick                         one millisecond tick per word
// out_o     out  segments_n, select_n         one digit refresh per word
// cfg_*     in   cfg_idx_i, cfg_wdata_i       text and scan period writes
//
// One word a cycle is taken while out_o is not stalled; a tick word ending a
// scan period reaches out_o through input register, then result register.
// Reset clears the counters, the text and sets the scan period to five.
// A stalled result holds out_o and blocks the input register and the scan counters behind it.
module seven_segment_text_scanner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sstx_tick_if.sink                     in_i,
  sstx_disp_if.source                   out_o,
  input  logic                          cfg_we_i,
  input  logic [sstx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sstx_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sstx_pkg::*;

  logic [TextW-1:0]   text_q;
  logic [PeriodW-1:0] period_q;

  logic       s1_valid_q;
  logic       s1_tick_q;
  logic       out_valid_q;
  logic [7:0] seg_q;
  logic [2:0] sel_q;

  logic      adv;
  logic      step;
  scan_res_t res;

  assign adv       = !out_valid_q || out_o.ready;
  assign step      = s1_valid_q && s1_tick_q && adv;
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q   <= '0;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TEXT:   text_q   <= cfg_wdata_i[TextW-1:0];
        REG_PERIOD: period_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_tick_q <= in_i.tick;
    end
  end

  sstx_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .text_i   (text_q),
    .period_i (period_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && res.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.fire) begin
      seg_q <= res.segments_n;
      sel_q <= res.select_n;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.segments_n = seg_q;
  assign out_o.select_n   = sel_q;

endmodule

// ----- hdl/sstx_checker.sv -----
module sstx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_segments_n_i,
  input logic [2:0] out_select_n_i
);

  a_one_digit_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones(out_select_n_i) == 2)
    else $error("select_n does not light exactly one digit");

  a_busy_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled result");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_segments_n_i) && $stable(out_select_n_i))
    else $error("result changed while stalled");

endmodule

bind seven_segment_text_scanner_core sstx_checker u_sstx_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_segments_n_i (out_o.segments_n),
  .out_select_n_i   (out_o.select_n)
);
